/* rtl/csqrt_pkg.sv */
// Shared constants, types and helpers for the complex square root pipeline.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package csqrt_pkg;

   // Number format of the operand and the root.
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 32;
   localparam int RE_W      = 24;
   localparam int IM_W      = 25;

   // Magnitude path: the exact squared magnitude and its 32-bit root.
   localparam int SQ_W  = 2 * IN_W;
   localparam int MAG_W = SQ_W / 2;

   // Half-root path: r + x and r - x, clamped, then scaled by 2^(FRAC_BITS-1).
   localparam int SUM_W       = MAG_W + 2;
   localparam int HALF_IN_W   = MAG_W + 1;
   localparam int HALF_SHIFT  = FRAC_BITS - 1;
   localparam int HALF_ROOT_W = (HALF_IN_W + HALF_SHIFT + 1) / 2;
   localparam int HALF_RAD_W  = 2 * HALF_ROOT_W;

   // Largest root that fits the output fields.
   localparam logic [RE_W-1:0] ROOT_MAX = '1;

   // Cycles from an accepted item to its result strobe.
   localparam int LATENCY   = MAG_W + HALF_ROOT_W + 4;
   localparam int LAT_CNT_W = $clog2(LATENCY + 1);

   // Lane numbers of the two half roots.
   localparam int LANE_RE = 0;
   localparam int LANE_IM = 1;
   localparam int LANES   = 2;

   // Magnitude unit to half-root stage.
   typedef struct packed {
      logic                   valid;
      logic [MAG_W-1:0]       mag;
      logic signed [IN_W-1:0] real_val;
      logic                   imag_neg;
   } mag_result_type;

   // Into the half-root unit.
   typedef struct packed {
      logic                              valid;
      logic                              imag_neg;
      logic [LANES-1:0][HALF_RAD_W-1:0]  rad;
   } half_in_type;

   // Out of the half-root unit.
   typedef struct packed {
      logic                              valid;
      logic                              imag_neg;
      logic [LANES-1:0][HALF_ROOT_W-1:0] root;
   } half_out_type;

   // Clip a half root to the output range.
   function automatic logic [RE_W-1:0] sat_root(input logic [HALF_ROOT_W-1:0] root);
      logic [31:0] wide;
      wide = 32'(root);
      if (wide > 32'(ROOT_MAX)) begin
         return ROOT_MAX;
      end
      return wide[RE_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/csqrt_mag.sv */
// Magnitude unit: squares both parts, adds them and takes the integer root,
// one result bit per pipeline stage. Depends on csqrt_pkg.
`default_nettype none

module csqrt_mag import csqrt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [IN_W-1:0] in_real,
   input  logic signed [IN_W-1:0] in_imag,
   output mag_result_type         mag_out
);

   logic [IN_W-1:0]        abs_x, abs_y;
   logic [SQ_W-1:0]        sqx_in, sqy_in, sum_in;

   logic                   sq_vld_ff;
   logic [SQ_W-1:0]        sqx_ff, sqy_ff;
   logic signed [IN_W-1:0] sq_real_ff;
   logic                   sq_neg_ff;

   logic                   vld_ff  [0:MAG_W];
   logic [MAG_W-1:0]       root_ff [0:MAG_W];
   logic signed [IN_W-1:0] real_ff [0:MAG_W];
   logic                   neg_ff  [0:MAG_W];
   logic [MAG_W+1:0]       rem_ff  [0:MAG_W-1];
   logic [SQ_W-1:0]        rad_ff  [0:MAG_W-1];

   // Magnitudes of both parts; the most negative value maps to 2^31.
   always_comb begin
      abs_x  = in_real[IN_W-1] ? IN_W'(-in_real) : IN_W'(in_real);
      abs_y  = in_imag[IN_W-1] ? IN_W'(-in_imag) : IN_W'(in_imag);
      sqx_in = abs_x * abs_x;
      sqy_in = abs_y * abs_y;
      sum_in = sqx_ff + sqy_ff;
   end

   // Square stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff     <= sqx_in;
      sqy_ff     <= sqy_in;
      sq_real_ff <= in_real;
      sq_neg_ff  <= in_imag[IN_W-1];
   end

   // Sum stage, which also seeds the root recurrence.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= sq_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff[0]  <= sum_in;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      real_ff[0] <= sq_real_ff;
      neg_ff[0]  <= sq_neg_ff;
   end

   // One restoring root step per stage: bring down two radicand bits and
   // subtract the trial value when it fits.
   for (genvar i = 0; i < MAG_W; i++) begin : g_root
      logic [MAG_W+1:0] pre;
      logic [MAG_W+1:0] trial;
      logic             fits;

      always_comb begin
         pre   = {rem_ff[i][MAG_W-1:0], rad_ff[i][SQ_W-1 -: 2]};
         trial = {root_ff[i], 2'b01};
         fits  = (pre >= trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         root_ff[i+1] <= {root_ff[i][MAG_W-2:0], fits};
         real_ff[i+1] <= real_ff[i];
         neg_ff[i+1]  <= neg_ff[i];
      end

      // The last step needs no remainder or radicand after it.
      if (i < MAG_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[i+1] <= fits ? (pre - trial) : pre;
            rad_ff[i+1] <= rad_ff[i] << 2;
         end
      end
   end

   assign mag_out.valid    = vld_ff[MAG_W];
   assign mag_out.mag      = root_ff[MAG_W];
   assign mag_out.real_val = real_ff[MAG_W];
   assign mag_out.imag_neg = neg_ff[MAG_W];

endmodule

`default_nettype wire

/* rtl/csqrt_half.sv */
// Half-root unit: two lanes of pipelined integer roots, one for the real
// part and one for the imaginary part, one result bit per stage. Depends on csqrt_pkg.
`default_nettype none

module csqrt_half import csqrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  half_in_type  half_in,
   output half_out_type half_out
);

   logic                   vld_ff  [0:HALF_ROOT_W];
   logic                   neg_ff  [0:HALF_ROOT_W];
   logic [HALF_ROOT_W-1:0] root_ff [0:LANES-1][0:HALF_ROOT_W];
   logic [HALF_ROOT_W+1:0] rem_ff  [0:LANES-1][0:HALF_ROOT_W-1];
   logic [HALF_RAD_W-1:0]  rad_ff  [0:LANES-1][0:HALF_ROOT_W-1];

   // Item tag: valid bit and sign of the imaginary input.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= half_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff[0] <= half_in.imag_neg;
   end

   for (genvar i = 0; i < HALF_ROOT_W; i++) begin : g_tag
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   // Both lanes run the same restoring recurrence side by side.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      always_ff @(posedge clock) begin
         rad_ff[l][0]  <= half_in.rad[l];
         rem_ff[l][0]  <= '0;
         root_ff[l][0] <= '0;
      end

      for (genvar i = 0; i < HALF_ROOT_W; i++) begin : g_step
         logic [HALF_ROOT_W+1:0] pre;
         logic [HALF_ROOT_W+1:0] trial;
         logic                   fits;

         always_comb begin
            pre   = {rem_ff[l][i][HALF_ROOT_W-1:0], rad_ff[l][i][HALF_RAD_W-1 -: 2]};
            trial = {root_ff[l][i], 2'b01};
            fits  = (pre >= trial);
         end

         always_ff @(posedge clock) begin
            root_ff[l][i+1] <= {root_ff[l][i][HALF_ROOT_W-2:0], fits};
         end

         if (i < HALF_ROOT_W - 1) begin : g_rem
            always_ff @(posedge clock) begin
               rem_ff[l][i+1] <= fits ? (pre - trial) : pre;
               rad_ff[l][i+1] <= rad_ff[l][i] << 2;
            end
         end
      end

      assign half_out.root[l] = root_ff[l][HALF_ROOT_W];
   end

   assign half_out.valid    = vld_ff[HALF_ROOT_W];
   assign half_out.imag_neg = neg_ff[HALF_ROOT_W];

endmodule

`default_nettype wire

/* rtl/complex_square_root_top.sv */
// Top level of the complex square root pipeline: magnitude unit, radicand
// forming, half-root unit and output register. Depends on csqrt_pkg, csqrt_mag, csqrt_half.
//
// Principal square root of one complex Q16.16 operand per clock. busy is
// always low, so an item is taken at every edge where start is high, and its
// result appears on the rsp_ ports, marked by rsp_valid for one cycle,
// after 32 magnitude root stages, 24 half-root stages and 4 stages for
// squaring, summing, radicand forming and output.
// Results come out in the order items went in, one per cycle at most; the
// receiver cannot stall them and must take each one when rsp_valid is high.
// The real part of the root is never negative; the imaginary part carries
// the sign of the imaginary operand, a zero imaginary operand counting as positive.
`default_nettype none

module complex_square_root_top import csqrt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [IN_W-1:0] req_real_part,
   input  logic signed [IN_W-1:0] req_imag_part,
   output logic                   rsp_valid,
   output logic [RE_W-1:0]        rsp_root_real,
   output logic signed [IM_W-1:0] rsp_root_imag
);

   mag_result_type          mag_out;
   half_in_type             half_in;
   half_out_type            half_out;

   logic signed [SUM_W-1:0] sum_p, sum_m;
   logic [HALF_IN_W-1:0]    clamp_p, clamp_m;
   logic [RE_W-1:0]         real_mag, imag_mag;
   logic [IM_W-1:0]         imag_wide;

   logic                    rsp_valid_in, rsp_valid_ff;
   logic [RE_W-1:0]         rsp_real_in, rsp_real_ff;
   logic [IM_W-1:0]         rsp_imag_in, rsp_imag_ff;

   // The pipeline takes an item every cycle.
   assign busy = 1'b0;

   csqrt_mag u_mag (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_real  (req_real_part),
      .in_imag  (req_imag_part),
      .mag_out  (mag_out)
   );

   // Radicands r + x and r - x, clamped at zero and scaled for the halving root.
   always_comb begin
      sum_p   = $signed({2'b00, mag_out.mag}) + SUM_W'(mag_out.real_val);
      sum_m   = $signed({2'b00, mag_out.mag}) - SUM_W'(mag_out.real_val);
      clamp_p = sum_p[SUM_W-1] ? '0 : sum_p[HALF_IN_W-1:0];
      clamp_m = sum_m[SUM_W-1] ? '0 : sum_m[HALF_IN_W-1:0];

      half_in.valid        = mag_out.valid;
      half_in.imag_neg     = mag_out.imag_neg;
      half_in.rad[LANE_RE] = HALF_RAD_W'(clamp_p) << HALF_SHIFT;
      half_in.rad[LANE_IM] = HALF_RAD_W'(clamp_m) << HALF_SHIFT;
   end

   csqrt_half u_half (
      .clock    (clock),
      .reset    (reset),
      .half_in  (half_in),
      .half_out (half_out)
   );

   // Saturate both roots and apply the sign of the imaginary operand.
   always_comb begin
      real_mag     = sat_root(half_out.root[LANE_RE]);
      imag_mag     = sat_root(half_out.root[LANE_IM]);
      imag_wide    = {1'b0, imag_mag};
      rsp_valid_in = half_out.valid;
      rsp_real_in  = real_mag;
      rsp_imag_in  = half_out.imag_neg ? (~imag_wide + 1'b1) : imag_wide;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_real_ff <= rsp_real_in;
      rsp_imag_ff <= rsp_imag_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root_real = rsp_real_ff;
   assign rsp_root_imag = $signed(rsp_imag_ff);

endmodule

`default_nettype wire

/* rtl/csqrt_checker.sv */
// Port-level checks for the complex square root pipeline, bound to the top level.
// Depends on csqrt_pkg and complex_square_root_top.
`default_nettype none

module csqrt_checker import csqrt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic signed [IN_W-1:0] req_real_part,
   input logic signed [IN_W-1:0] req_imag_part,
   input logic                   rsp_valid,
   input logic [RE_W-1:0]        rsp_root_real,
   input logic signed [IM_W-1:0] rsp_root_imag
);

   logic [LAT_CNT_W-1:0] since_rst_ff;
   logic [LAT_CNT_W-1:0] since_rst_in;
   logic                 armed;

   // Count cycles since reset so that checks look back only over clean history.
   always_comb begin
      armed        = (since_rst_ff == LAT_CNT_W'(LATENCY));
      since_rst_in = armed ? since_rst_ff : since_rst_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_rst_ff <= '0;
      end else begin
         since_rst_ff <= since_rst_in;
      end
   end

   // Every accepted item yields exactly one strobe, a fixed time later.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      armed |-> (rsp_valid == $past(start && !busy, LATENCY)))
      else $error("result strobe does not match accepted item");

   // The root of zero is zero.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      armed && $past(start && !busy && req_real_part == 0 && req_imag_part == 0, LATENCY)
      |-> (rsp_root_real == 0 && rsp_root_imag == 0))
      else $error("root of zero is not zero");

   // A non-negative imaginary operand gives a non-negative imaginary root.
   a_imag_pos: assert property (@(posedge clock) disable iff (reset)
      armed && $past(start && !busy && !req_imag_part[IN_W-1], LATENCY)
      |-> !rsp_root_imag[IM_W-1])
      else $error("imaginary root negative for non-negative operand");

   // A negative imaginary operand gives a negative or zero imaginary root.
   a_imag_neg: assert property (@(posedge clock) disable iff (reset)
      armed && $past(start && !busy && req_imag_part[IN_W-1], LATENCY)
      |-> (rsp_root_imag[IM_W-1] || rsp_root_imag == 0))
      else $error("imaginary root positive for negative operand");

endmodule

bind complex_square_root_top csqrt_checker u_checker (.*);

`default_nettype wire

/* test/tb_complex_square_root_top.sv */
// Self-checking testbench for complex_square_root_top: directed and random operands
// with random idle bursts, checked against a built-in principal-root predictor.
// Depends on csqrt_pkg and the complex_square_root_top RTL only.
`timescale 1ns / 1ps

module tb_complex_square_root_top;
   import csqrt_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int TAIL_ITEMS    = 300;
   localparam int SEGMENT_ITEMS = 200;
   localparam int DRAIN_EVERY   = 400;
   localparam int MAX_GAP       = 17;
   localparam int REPORT_LIMIT  = 10;
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic signed [IN_W-1:0] OPND_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [IN_W-1:0] OPND_MIN = 32'sh8000_0000;
   localparam logic signed [IN_W-1:0] ONE      = 32'sh0001_0000;

   // Shapes of random operands.
   typedef enum int {
      SHAPE_ANY,
      SHAPE_SMALL,
      SHAPE_IMAG_ZERO,
      SHAPE_REAL_ZERO,
      SHAPE_NEAR_EXTREME,
      SHAPE_WHOLE,
      SHAPE_COUNT
   } operand_shape_type;

   typedef struct {
      logic signed [IN_W-1:0] re;
      logic signed [IN_W-1:0] im;
      int                     gap_pct;
      bit                     drain_first;
   } operand_item_type;

   typedef struct {
      logic signed [IN_W-1:0] re;
      logic signed [IN_W-1:0] im;
      logic [RE_W-1:0]        root_real;
      logic signed [IM_W-1:0] root_imag;
   } expected_root_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic signed [IN_W-1:0] req_real_part = '0;
   logic signed [IN_W-1:0] req_imag_part = '0;
   logic                   rsp_valid;
   logic [RE_W-1:0]        rsp_root_real;
   logic signed [IM_W-1:0] rsp_root_imag;

   operand_item_type  pending_items[$];
   expected_root_type expected_roots[$];

   operand_item_type  head_item;
   expected_root_type oldest_root;
   logic              next_start;
   bit                head_ready = 1'b0;
   int                gap_left = 0;
   int                current_gap_pct = 0;
   int                items_taken = 0;
   int                roots_checked = 0;
   int                neg_imag_items = 0;
   int                neg_real_on_axis = 0;
   int                mismatches = 0;
   int                cycle_count = 0;

   complex_square_root_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_real_part (req_real_part),
      .req_imag_part (req_imag_part),
      .rsp_valid     (rsp_valid),
      .rsp_root_real (rsp_root_real),
      .rsp_root_imag (rsp_root_imag)
   );

   always #CLK_HALF clock = ~clock;

   // Integer square root, truncated.
   function automatic logic [63:0] floor_sqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] probe;
      rem   = v;
      res   = '0;
      probe = 64'h1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   // floor(sqrt(h / 2)) at the fixed-point scale, clamped below at zero and
   // saturated to the output range.
   function automatic logic [RE_W-1:0] half_root_of(input longint h);
      longint      clamped;
      logic [63:0] q;
      clamped = (h < 0) ? 0 : h;
      q = floor_sqrt64(64'(clamped) << (FRAC_BITS - 1));
      if (q > 64'(ROOT_MAX)) return ROOT_MAX;
      return q[RE_W-1:0];
   endfunction

   // Principal square root of re + i*im.
   function automatic expected_root_type predict_principal_root(
      input logic signed [IN_W-1:0] re,
      input logic signed [IN_W-1:0] im
   );
      expected_root_type res;
      longint            x;
      longint            y;
      longint            mag;
      logic [63:0]       ax;
      logic [63:0]       ay;
      logic [RE_W-1:0]   imag_mag;
      x   = re;
      y   = im;
      ax  = (x < 0) ? 64'(-x) : 64'(x);
      ay  = (y < 0) ? 64'(-y) : 64'(y);
      mag = longint'(floor_sqrt64(ax * ax + ay * ay));
      imag_mag      = half_root_of(mag - x);
      res.re        = re;
      res.im        = im;
      res.root_real = half_root_of(mag + x);
      // A zero imaginary part counts as positive.
      res.root_imag = (y < 0) ? -$signed({1'b0, imag_mag}) : $signed({1'b0, imag_mag});
      return res;
   endfunction

   task automatic queue_operand(input logic signed [IN_W-1:0] re,
                                input logic signed [IN_W-1:0] im,
                                input bit drain_first);
      operand_item_type it;
      it.re          = re;
      it.im          = im;
      it.gap_pct     = current_gap_pct;
      it.drain_first = drain_first;
      pending_items.push_back(it);
   endtask

   function automatic logic signed [IN_W-1:0] random_part(input operand_shape_type shape);
      logic signed [IN_W-1:0] v;
      case (shape)
         SHAPE_SMALL: begin
            v = $signed(IN_W'($urandom_range(32'h0010_0000, 0)));
         end
         SHAPE_NEAR_EXTREME: begin
            v = OPND_MAX - $signed(IN_W'($urandom_range(255, 0)));
         end
         SHAPE_WHOLE: begin
            v = $signed(IN_W'($urandom_range(32767, 0))) <<< FRAC_BITS;
         end
         default: begin
            v = $signed($urandom);
         end
      endcase
      if (shape != SHAPE_ANY && $urandom_range(1, 0) == 1) v = -v - 1;
      return v;
   endfunction

   task automatic report_mismatch(input string what, input expected_root_type e);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("[%0t] %s: operand (%0d, %0d) expected (%0d, %0d) got (%0d, %0d)",
                  $time, what, e.re, e.im, e.root_real, e.root_imag,
                  rsp_root_real, rsp_root_imag);
      end
   endtask

   // Driver: offers the oldest pending item, with random idle bursts before
   // each item and an optional wait until the pipeline has emptied.
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         gap_left   = 0;
         head_ready = 1'b0;
      end else begin
         next_start = 1'b0;
         if (start && !busy) begin
            head_item = pending_items.pop_front();
            expected_roots.push_back(predict_principal_root(head_item.re, head_item.im));
            items_taken++;
            if (head_item.im < 0) neg_imag_items++;
            if (head_item.im == 0 && head_item.re < 0) neg_real_on_axis++;
            head_ready = 1'b0;
         end
         if (pending_items.size() != 0) begin
            head_item = pending_items[0];
            if (!head_ready && !(head_item.drain_first && expected_roots.size() != 0)) begin
               head_ready = 1'b1;
               if ($urandom_range(99, 0) < head_item.gap_pct) begin
                  gap_left = $urandom_range(MAX_GAP, 1);
               end
            end
            if (head_ready) begin
               if (gap_left != 0) begin
                  gap_left--;
               end else begin
                  next_start    = 1'b1;
                  req_real_part <= head_item.re;
                  req_imag_part <= head_item.im;
               end
            end
         end
         start <= next_start;
      end
   end

   // Monitor: every strobed result is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_roots.size() == 0) begin
            oldest_root = '{default: '0};
            report_mismatch("result with no item outstanding", oldest_root);
         end else begin
            oldest_root = expected_roots.pop_front();
            roots_checked++;
            if (rsp_root_real !== oldest_root.root_real ||
                rsp_root_imag !== oldest_root.root_imag) begin
               report_mismatch("root mismatch", oldest_root);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d items pending",
                  cycle_count, pending_items.size());
         $display("** complex_square_root_top: FAILED **");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      operand_shape_type shape;
      logic signed [IN_W-1:0] re;
      logic signed [IN_W-1:0] im;

      // Directed operands: axes, extremes, signs and a zero imaginary part
      // with a negative real part.
      queue_operand('0, '0, 1'b0);
      queue_operand(OPND_MAX, '0, 1'b0);
      queue_operand(OPND_MIN, '0, 1'b0);
      queue_operand('0, OPND_MAX, 1'b0);
      queue_operand('0, OPND_MIN, 1'b0);
      queue_operand(OPND_MIN, OPND_MIN, 1'b0);
      queue_operand(OPND_MAX, OPND_MAX, 1'b0);
      queue_operand(OPND_MIN, OPND_MAX, 1'b0);
      queue_operand(OPND_MAX, OPND_MIN, 1'b0);
      queue_operand(-ONE, '0, 1'b0);
      queue_operand(-32'sd1, '0, 1'b0);
      queue_operand(ONE, '0, 1'b0);
      queue_operand('0, -ONE, 1'b0);
      queue_operand(32'sd1, 32'sd1, 1'b0);
      queue_operand(-32'sd1, -32'sd1, 1'b0);
      queue_operand(3 * ONE, 4 * ONE, 1'b0);
      queue_operand(-3 * ONE, -4 * ONE, 1'b0);
      queue_operand(-4 * ONE, 32'sd1, 1'b0);
      queue_operand(-4 * ONE, -32'sd1, 1'b0);
      queue_operand(32'sd1, OPND_MIN, 1'b0);
      queue_operand(-32'sh5555_5555, 32'sh2AAA_AAAA, 1'b0);

      // Random operands in segments of differing idle density; the final
      // stretch has no idle bursts.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - TAIL_ITEMS) begin
            current_gap_pct = 0;
         end else if (n % SEGMENT_ITEMS == 0) begin
            case ($urandom_range(3, 0))
               0:       current_gap_pct = 0;
               1:       current_gap_pct = 5;
               2:       current_gap_pct = 25;
               default: current_gap_pct = 60;
            endcase
         end
         shape = operand_shape_type'($urandom_range(SHAPE_COUNT - 1, 0));
         re = random_part(shape);
         im = random_part(shape);
         if (shape == SHAPE_IMAG_ZERO) im = '0;
         if (shape == SHAPE_REAL_ZERO) re = '0;
         if (shape == SHAPE_NEAR_EXTREME && $urandom_range(1, 0) == 1) im = random_part(SHAPE_ANY);
         queue_operand(re, im, n % DRAIN_EVERY == 0);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || expected_roots.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      $display("Sent %0d operands (%0d with negative imaginary part, %0d on the negative real axis),",
               items_taken, neg_imag_items, neg_real_on_axis);
      $display("checked %0d roots, %0d mismatches.", roots_checked, mismatches);
      if (mismatches == 0 && expected_roots.size() == 0) begin
         $display("** complex_square_root_top: PASSED **");
      end else begin
         $display("** complex_square_root_top: FAILED **");
      end
      $finish;
   end

endmodule
